// ===== rtl/protected_id_table_unit_macros.svh =====
// assertion macros used by the protected id table datapath
`ifndef PROTECTED_ID_TABLE_UNIT_MACROS_SVH
`define PROTECTED_ID_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PIDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidt assertion failed");

// next-cycle implication, checked outside reset
`define PIDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidt assertion failed");

`endif

// ===== rtl/pidt_pkg.sv =====
// shared codes and controller/datapath interface types for the protected id table
package pidt_pkg;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_CHECK  = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_LIST   = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID_ID = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NO_MATCH   = 3'd3;
    localparam logic [2:0] ST_SKIPPED    = 3'd4;
    localparam logic [2:0] ST_BAD_ACTION = 3'd5;

    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic in_load;
        logic idx_clr;
        logic scan_step;
        logic list_rd;
        logic commit;
        logic list_out;
    } cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       req_failed;
        logic       ident_zero;
        logic       count_zero;
        logic       slot0_used;
        logic       idx_last;
        logic       list_last;
        logic       out_free;
    } sts_t;

endpackage

// ===== rtl/pidt_ctrl.sv =====
// sequencing state machine for the protected id table
module pidt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pidt_pkg::sts_t  sts,
    output pidt_pkg::cmd_t  cmd
);

    typedef enum logic [6:0]
    {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_DRAIN    = 7'b0001000,
        S_COMMIT   = 7'b0010000,
        S_LIST_RD  = 7'b0100000,
        S_LIST_OUT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.idx_clr = 1'b1;
                case (sts.act)
                    pidt_pkg::ACT_ADD:
                    begin
                        if (sts.req_failed || sts.ident_zero)
                            state_next = S_COMMIT;
                        else
                            state_next = S_SCAN;
                    end
                    pidt_pkg::ACT_REMOVE:
                    begin
                        if (sts.req_failed || sts.ident_zero || sts.count_zero)
                            state_next = S_COMMIT;
                        else
                            state_next = S_SCAN;
                    end
                    pidt_pkg::ACT_CHECK:
                    begin
                        state_next = S_SCAN;
                    end
                    pidt_pkg::ACT_LIST:
                    begin
                        if (sts.slot0_used)
                            state_next = S_LIST_RD;
                        else
                            state_next = S_COMMIT;
                    end
                    default:
                    begin
                        state_next = S_COMMIT;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.idx_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last slot read is compared in this cycle
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                cmd.list_rd = 1'b1;
                state_next  = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.list_out = 1'b1;
                    if (sts.list_last)
                        state_next = S_IDLE;
                    else
                        state_next = S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/pidt_dp.sv =====
// id slot memory, scan logic, live count and result register
`include "protected_id_table_unit_macros.svh"

module pidt_dp
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  pidt_pkg::cmd_t  cmd,
    output pidt_pkg::sts_t  sts,
    input  logic [2:0]      action,
    input  logic [31:0]     ident,
    input  logic [31:0]     access_in,
    input  logic            from_kernel,
    input  logic            request_end,
    input  logic            out_stall,
    output logic            out_valid,
    output logic [2:0]      status,
    output logic            changed,
    output logic            found,
    output logic [31:0]     access_out,
    output logic [31:0]     listed_id,
    output logic [5:0]      entry_count,
    output logic            last
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // latched request beat
    logic [2:0]             act_reg;
    logic [31:0]            ident_reg;
    logic [31:0]            access_reg;
    logic                   kernel_reg;
    logic                   end_reg;

    // table state
    logic [31:0]            slot_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   failed_reg;
    logic                   failed_next;

    // scan
    logic [IW-1:0]          idx_reg;
    logic [31:0]            rd_data_reg;
    logic                   rd_live_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic                   pend_reg;
    logic                   hit_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic                   empty_reg;
    logic [IW-1:0]          empty_idx_reg;
    logic                   rd_en;

    // result register
    logic                   out_valid_reg;
    logic [2:0]             status_reg;
    logic                   changed_reg;
    logic                   found_reg;
    logic [31:0]            access_out_reg;
    logic [31:0]            listed_reg;
    logic [5:0]             count_out_reg;
    logic                   last_reg;

    logic [2:0]             res_status;
    logic                   res_changed;
    logic                   res_found;
    logic [31:0]            res_access;
    logic                   is_req;
    logic                   do_write;
    logic                   do_remove;
    logic                   do_clear;
    logic                   out_free;
    logic                   list_last;
    logic [CW-1:0]          nxt_idx;
    logic [TABLE_DEPTH:0]   valid_ext;

    assign rd_en    = cmd.scan_step | cmd.list_rd;
    assign out_free = !out_valid_reg || !out_stall;

    // a listed slot is the final beat when the next slot is empty or past the end
    assign nxt_idx   = CW'(rd_idx_reg) + CW'(1);
    assign valid_ext = {1'b0, valid_reg};
    assign list_last = !valid_ext[nxt_idx] || (int'(nxt_idx) >= pidt_pkg::MAX_RESULTS);

    assign sts.act        = act_reg;
    assign sts.req_failed = failed_reg;
    assign sts.ident_zero = (ident_reg == 32'd0);
    assign sts.count_zero = (count_reg == '0);
    assign sts.slot0_used = valid_reg[0];
    assign sts.idx_last   = (idx_reg == IW'(TABLE_DEPTH - 1));
    assign sts.list_last  = list_last;
    assign sts.out_free   = out_free;

    always_comb
    begin
        res_status  = pidt_pkg::ST_OK;
        res_changed = 1'b0;
        res_found   = 1'b0;
        res_access  = 32'd0;
        is_req      = 1'b0;
        do_write    = 1'b0;
        do_remove   = 1'b0;
        do_clear    = 1'b0;
        case (act_reg)
            pidt_pkg::ACT_ADD:
            begin
                is_req = 1'b1;
                if (failed_reg)
                    res_status = pidt_pkg::ST_SKIPPED;
                else if (ident_reg == 32'd0)
                    res_status = pidt_pkg::ST_INVALID_ID;
                else if (hit_reg)
                    res_found = 1'b1;
                else if ((int'(count_reg) >= TABLE_DEPTH) || !empty_reg)
                    res_status = pidt_pkg::ST_FULL;
                else
                begin
                    res_changed = 1'b1;
                    do_write    = cmd.commit;
                end
            end
            pidt_pkg::ACT_REMOVE:
            begin
                is_req = 1'b1;
                if (failed_reg)
                    res_status = pidt_pkg::ST_SKIPPED;
                else if (ident_reg == 32'd0)
                    res_status = pidt_pkg::ST_INVALID_ID;
                else if (count_reg == '0)
                    res_status = pidt_pkg::ST_NO_MATCH;
                else if (hit_reg)
                begin
                    res_changed = 1'b1;
                    res_found   = 1'b1;
                    do_remove   = cmd.commit;
                end
            end
            pidt_pkg::ACT_CHECK:
            begin
                res_found = hit_reg;
                if (hit_reg && !kernel_reg)
                    res_access = access_reg & ~32'd1;
                else
                    res_access = access_reg;
            end
            pidt_pkg::ACT_CLEAR:
            begin
                res_changed = (count_reg != '0);
                do_clear    = cmd.commit;
            end
            pidt_pkg::ACT_LIST:
            begin
                res_status = pidt_pkg::ST_OK;
            end
            default:
            begin
                res_status = pidt_pkg::ST_BAD_ACTION;
            end
        endcase
    end

    always_comb
    begin
        valid_next  = valid_reg;
        count_next  = count_reg;
        failed_next = failed_reg;
        if (do_clear)
        begin
            valid_next = '0;
            count_next = '0;
        end
        else if (do_write)
        begin
            valid_next[empty_idx_reg] = 1'b1;
            count_next = count_reg + CW'(1);
        end
        else if (do_remove)
        begin
            valid_next[hit_idx_reg] = 1'b0;
            count_next = count_reg - CW'(1);
        end
        // skipped status implies the mark was already set
        if (cmd.commit && is_req)
            failed_next = (res_status != pidt_pkg::ST_OK) && !end_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            act_reg    <= action;
            ident_reg  <= ident;
            access_reg <= access_in;
            kernel_reg <= from_kernel;
            end_reg    <= request_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            slot_mem[empty_idx_reg] <= ident_reg;
        if (rd_en)
            rd_data_reg <= slot_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            idx_reg       <= '0;
            rd_live_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            empty_reg     <= 1'b0;
            empty_idx_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            failed_reg <= failed_next;
            pend_reg   <= cmd.scan_step;
            if (rd_en)
            begin
                rd_live_reg <= valid_reg[idx_reg];
                rd_idx_reg  <= idx_reg;
            end
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.scan_step || cmd.list_out)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.idx_clr)
            begin
                hit_reg   <= 1'b0;
                empty_reg <= 1'b0;
            end
            else
            begin
                // first free slot found at read issue
                if (cmd.scan_step && !valid_reg[idx_reg] && !empty_reg)
                begin
                    empty_reg     <= 1'b1;
                    empty_idx_reg <= idx_reg;
                end
                // match compared in the following cycle on registered read data
                if (pend_reg && rd_live_reg && (rd_data_reg == ident_reg) && !hit_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit || cmd.list_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg     <= res_status;
            changed_reg    <= res_changed;
            found_reg      <= res_found;
            access_out_reg <= res_access;
            listed_reg     <= 32'd0;
            count_out_reg  <= 6'(count_next);
            last_reg       <= 1'b1;
        end
        else if (cmd.list_out)
        begin
            status_reg     <= pidt_pkg::ST_OK;
            changed_reg    <= 1'b0;
            found_reg      <= 1'b0;
            access_out_reg <= 32'd0;
            listed_reg     <= rd_data_reg;
            count_out_reg  <= 6'(count_reg);
            last_reg       <= list_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign changed     = changed_reg;
    assign found       = found_reg;
    assign access_out  = access_out_reg;
    assign listed_id   = listed_reg;
    assign entry_count = count_out_reg;
    assign last        = last_reg;

    `PIDT_ASSERT_IMPL(a_count_matches_valid, clk, rst_n, 1'b1, $countones(valid_reg) == int'(count_reg))
    `PIDT_ASSERT_IMPL(a_load_needs_room, clk, rst_n, cmd.commit || cmd.list_out, out_free)
    `PIDT_ASSERT_NEXT(a_commit_shows_beat, clk, rst_n, cmd.commit, out_valid_reg && last_reg)
    `PIDT_ASSERT_IMPL(a_list_beat_nonzero, clk, rst_n, cmd.list_out, rd_data_reg != 32'd0)

endmodule

// ===== rtl/protected_id_table_unit.sv =====
// protected id table: top level joining controller and datapath
//
//  channel  direction  handshake           payload
//  in       to block   in_valid/in_stall   action ident access_in from_kernel request_end
//  out      from block out_valid/out_stall status changed found access_out listed_id
//                                          entry_count last
//
// add, remove and check scan every slot before the result is loaded
// clear, invalid action and rejected requests skip the scan; list reads and sends one slot per beat
// the slot memory has one read port, one slot is read per cycle during a scan
// reset empties the table at once through per-slot valid bits, no clearing pass
// a stalled result waits in the output register; the next beat is taken once
// the previous item's results are all loaded
module protected_id_table_unit
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [31:0] ident,
    input  logic [31:0] access_in,
    input  logic        from_kernel,
    input  logic        request_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        changed,
    output logic        found,
    output logic [31:0] access_out,
    output logic [31:0] listed_id,
    output logic [5:0]  entry_count,
    output logic        last
);

    pidt_pkg::cmd_t cmd;
    pidt_pkg::sts_t sts;

    pidt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pidt_dp
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (action),
        .ident       (ident),
        .access_in   (access_in),
        .from_kernel (from_kernel),
        .request_end (request_end),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .status      (status),
        .changed     (changed),
        .found       (found),
        .access_out  (access_out),
        .listed_id   (listed_id),
        .entry_count (entry_count),
        .last        (last)
    );

endmodule

// ===== tb/tb_protected_id_table_unit.sv =====
// self-checking testbench for the protected id table: directed table, then random requests
`timescale 1ns / 1ps

module tb_protected_id_table_unit;

    localparam int TABLE_DEPTH = 32;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 50;
    localparam int DIR_ROWS    = 25;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 400000;

    // actions the block does not implement
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] ident;
        logic [31:0] acc;
        logic        kern;
        logic        rend;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        changed;
        logic        found;
        logic [31:0] access_out;
        logic [31:0] listed_id;
        logic [5:0]  entry_count;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] ident;
        logic [31:0] acc;
        logic        kern;
        logic        rend;
        logic        typed;
        logic [2:0]  st;
        logic        chg;
        logic        fnd;
        logic [31:0] acc_out;
        logic [5:0]  cnt;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [31:0] ident;
    logic [31:0] access_in;
    logic        from_kernel;
    logic        request_end;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic        changed;
    logic        found;
    logic [31:0] access_out;
    logic [31:0] listed_id;
    logic [5:0]  entry_count;
    logic        last;

    // predictor state
    logic [31:0] slot_ids [TABLE_DEPTH];
    int          live_ids;
    logic        pend_fail;

    result_t     predicted_beats[$];
    result_t     pending_results[$];
    logic [31:0] id_pool [POOL_SIZE];

    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int results_seen;
    int fills_done;
    int mismatches;
    int cycle_count;

    // untyped rows are checked against the predictor
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{pidt_pkg::ACT_LIST,   32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_REMOVE, 32'h5,         32'h0,         1'b0, 1'b1, 1'b1,
          pidt_pkg::ST_NO_MATCH,   1'b0, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_ADD,    32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_INVALID_ID, 1'b0, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_ADD,    32'h7,         32'h0,         1'b0, 1'b1, 1'b1,
          pidt_pkg::ST_SKIPPED,    1'b0, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b1, 1'b0, 32'h0,         6'd1},
        '{pidt_pkg::ACT_ADD,    32'h1,         32'h0,         1'b0, 1'b1, 1'b1,
          pidt_pkg::ST_OK,         1'b1, 1'b0, 32'h0,         6'd2},
        '{pidt_pkg::ACT_ADD,    32'hFFFF_FFFF, 32'h0,         1'b0, 1'b1, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b1, 32'h0,         6'd2},
        '{pidt_pkg::ACT_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b1, 32'hFFFF_FFFE, 6'd2},
        '{pidt_pkg::ACT_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b1, 32'hFFFF_FFFF, 6'd2},
        '{pidt_pkg::ACT_CHECK,  32'h0,         32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'hFFFF_FFFF, 6'd2},
        '{pidt_pkg::ACT_CHECK,  32'h8000_0000, 32'h1,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h1,         6'd2},
        '{pidt_pkg::ACT_LIST,   32'h0,         32'h0,         1'b0, 1'b0, 1'b0,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_REMOVE, 32'h1,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b1, 1'b1, 32'h0,         6'd1},
        '{pidt_pkg::ACT_REMOVE, 32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_INVALID_ID, 1'b0, 1'b0, 32'h0,         6'd1},
        '{pidt_pkg::ACT_CHECK,  32'h1,         32'h3,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h3,         6'd1},
        '{pidt_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b1, 1'b1,
          pidt_pkg::ST_SKIPPED,    1'b0, 1'b0, 32'h0,         6'd1},
        '{pidt_pkg::ACT_REMOVE, 32'h0001_2345, 32'h0,         1'b0, 1'b1, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h0,         6'd1},
        '{pidt_pkg::ACT_ADD,    32'hA5A5_5A5A, 32'h0,         1'b0, 1'b0, 1'b0,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_LIST,   32'h0,         32'h0,         1'b0, 1'b0, 1'b0,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h0,         6'd0},
        '{ACT_RSVD5,            32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_BAD_ACTION, 1'b0, 1'b0, 32'h0,         6'd2},
        '{ACT_RSVD6,            32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_BAD_ACTION, 1'b0, 1'b0, 32'h0,         6'd2},
        '{ACT_RSVD7,            32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_BAD_ACTION, 1'b0, 1'b0, 32'h0,         6'd2},
        '{pidt_pkg::ACT_CLEAR,  32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b1, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_CLEAR,  32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h0,         6'd0},
        '{pidt_pkg::ACT_LIST,   32'h0,         32'h0,         1'b0, 1'b0, 1'b1,
          pidt_pkg::ST_OK,         1'b0, 1'b0, 32'h0,         6'd0}
    };

    protected_id_table_unit #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (.*);

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int slot_of(logic [31:0] id);
        if (id == 32'h0)
            return -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic req_t mk_req(logic [2:0] act, logic [31:0] id, logic [31:0] acc,
                                    logic kern, logic rend);
        req_t r;
        r.act   = act;
        r.ident = id;
        r.acc   = acc;
        r.kern  = kern;
        r.rend  = rend;
        return r;
    endfunction

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // works out the result beats of one table operation and updates the table copy
    task automatic predict_table_op(input req_t r);
        result_t res;
        int      hit;
        int      free_slot;
        predicted_beats.delete();
        res        = '0;
        res.status = pidt_pkg::ST_OK;
        res.last   = 1'b1;
        case (r.act)
            pidt_pkg::ACT_ADD:
            begin
                if (pend_fail)
                    res.status = pidt_pkg::ST_SKIPPED;
                else if (r.ident == 32'h0)
                begin
                    res.status = pidt_pkg::ST_INVALID_ID;
                    pend_fail  = 1'b1;
                end
                else if (slot_of(r.ident) >= 0)
                    res.found = 1'b1;
                else
                begin
                    free_slot = -1;
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (slot_ids[i] == 32'h0 && free_slot < 0)
                            free_slot = i;
                    if (live_ids >= TABLE_DEPTH || free_slot < 0)
                    begin
                        res.status = pidt_pkg::ST_FULL;
                        pend_fail  = 1'b1;
                    end
                    else
                    begin
                        slot_ids[free_slot] = r.ident;
                        live_ids++;
                        res.changed = 1'b1;
                    end
                end
                if (r.rend)
                    pend_fail = 1'b0;
            end
            pidt_pkg::ACT_REMOVE:
            begin
                if (pend_fail)
                    res.status = pidt_pkg::ST_SKIPPED;
                else if (r.ident == 32'h0)
                begin
                    res.status = pidt_pkg::ST_INVALID_ID;
                    pend_fail  = 1'b1;
                end
                else if (live_ids == 0)
                begin
                    res.status = pidt_pkg::ST_NO_MATCH;
                    pend_fail  = 1'b1;
                end
                else
                begin
                    hit = slot_of(r.ident);
                    if (hit >= 0)
                    begin
                        slot_ids[hit] = 32'h0;
                        live_ids--;
                        res.changed = 1'b1;
                        res.found   = 1'b1;
                    end
                end
                if (r.rend)
                    pend_fail = 1'b0;
            end
            pidt_pkg::ACT_CHECK:
            begin
                res.found      = slot_of(r.ident) >= 0;
                res.access_out = r.acc;
                if (res.found && !r.kern)
                    res.access_out[0] = 1'b0;
            end
            pidt_pkg::ACT_CLEAR:
            begin
                res.changed = live_ids != 0;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    slot_ids[i] = 32'h0;
                live_ids = 0;
            end
            pidt_pkg::ACT_LIST:
            begin
                res.last        = 1'b0;
                res.entry_count = live_ids[5:0];
                // stops at the first empty slot
                for (int i = 0;
                     i < TABLE_DEPTH && predicted_beats.size() < pidt_pkg::MAX_RESULTS;
                     i++)
                begin
                    if (slot_ids[i] == 32'h0)
                        break;
                    res.listed_id = slot_ids[i];
                    predicted_beats.push_back(res);
                end
                if (predicted_beats.size() == 0)
                begin
                    res.listed_id = 32'h0;
                    res.last      = 1'b1;
                    predicted_beats.push_back(res);
                end
                else
                    predicted_beats[predicted_beats.size() - 1].last = 1'b1;
            end
            default:
                res.status = pidt_pkg::ST_BAD_ACTION;
        endcase
        if (r.act != pidt_pkg::ACT_LIST)
        begin
            res.entry_count = live_ids[5:0];
            predicted_beats.push_back(res);
        end
    endtask

    // drives one beat at the falling edge and waits for it to be taken
    task automatic send_item(input req_t r, input logic typed, input result_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= r.act;
        ident       <= r.ident;
        access_in   <= r.acc;
        from_kernel <= r.kern;
        request_end <= r.rend;
        do
            @(posedge clk);
        while (in_stall);
        predict_table_op(r);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (predicted_beats[k])
                pending_results.push_back(predicted_beats[k]);
        items_sent++;
    endtask

    task automatic send_random(input logic [2:0] act);
        result_t none;
        none = '0;
        send_item(mk_req(act, pick_id(), $urandom, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))), 1'b0, none);
    endtask

    // sender holds off until every expected result beat is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge clk)
        out_stall <= $urandom_range(0, 99) < recv_stall_pct;

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected, status %0h", status);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("changed", 32'(want.changed), 32'(changed));
                check_field("found", 32'(want.found), 32'(found));
                check_field("access_out", want.access_out, access_out);
                check_field("listed_id", want.listed_id, listed_id);
                check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("protected_id_table_unit test failed");
            $finish;
        end
    end

    initial
    begin
        result_t  want;
        result_t  none;
        dir_row_t row;
        int       n_phase;
        int       len;
        int       pick;
        logic     filled;
        logic [2:0] act;
        logic [31:0] id;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = pidt_pkg::ACT_ADD;
        ident          = 32'h0;
        access_in      = 32'h0;
        from_kernel    = 1'b0;
        request_end    = 1'b0;
        out_stall      = 1'b0;
        send_idle_pct  = 35;
        recv_stall_pct = 76;
        items_sent     = 0;
        results_seen   = 0;
        fills_done     = 0;
        mismatches     = 0;
        cycle_count    = 0;
        none           = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_ids[i] = 32'h0;
        live_ids  = 0;
        pend_fail = 1'b0;
        // a small pool keeps adds, removes and checks hitting the same ids
        foreach (id_pool[i])
        begin
            id_pool[i] = $urandom;
            if (id_pool[i] == 32'h0)
                id_pool[i] = 32'h1 << i;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            row              = directed_rows[i];
            want             = '0;
            want.status      = row.st;
            want.changed     = row.chg;
            want.found       = row.fnd;
            want.access_out  = row.acc_out;
            want.entry_count = row.cnt;
            want.last        = 1'b1;
            send_item(mk_req(row.act, row.ident, row.acc, row.kern, row.rend), row.typed, want);
        end
        drain_results();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 35 : (ph == 1) ? 76 : 0;
            recv_stall_pct = (ph == 0) ? 76 : (ph == 1) ? 35 : 0;
            n_phase = 0;
            filled  = 1'b0;
            while (n_phase < PHASE_ITEMS)
            begin
                if (!filled && n_phase >= 20)
                begin
                    // fill to capacity, overflow once, then list the full table
                    filled = 1'b1;
                    fills_done++;
                    while (live_ids < TABLE_DEPTH)
                    begin
                        send_item(mk_req(pidt_pkg::ACT_ADD, $urandom | 32'h1, $urandom,
                                         1'b0, 1'b1),
                                  1'b0, none);
                        n_phase++;
                    end
                    send_item(mk_req(pidt_pkg::ACT_ADD, $urandom | 32'h1, $urandom,
                                     1'b0, 1'b1),
                              1'b0, none);
                    send_random(pidt_pkg::ACT_LIST);
                    n_phase += 2;
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 52)
                    begin
                        // multi-beat add or remove, sometimes with a zero id or no end mark
                        act = (pick < 30) ? pidt_pkg::ACT_ADD : pidt_pkg::ACT_REMOVE;
                        len = $urandom_range(1, 3);
                        for (int j = 0; j < len; j++)
                        begin
                            id = ($urandom_range(0, 19) == 0) ? 32'h0 : pick_id();
                            send_item(mk_req(act, id, $urandom, 1'($urandom_range(0, 1)),
                                             (j == len - 1) && ($urandom_range(0, 9) != 0)),
                                      1'b0, none);
                            n_phase++;
                        end
                    end
                    else
                    begin
                        if (pick < 74)
                            act = pidt_pkg::ACT_CHECK;
                        else if (pick < 86)
                            act = pidt_pkg::ACT_LIST;
                        else if (pick < 90)
                            act = pidt_pkg::ACT_CLEAR;
                        else if (pick < 94)
                            act = ACT_RSVD5;
                        else if (pick < 97)
                            act = ACT_RSVD6;
                        else
                            act = ACT_RSVD7;
                        send_random(act);
                        n_phase++;
                    end
                end
            end
            drain_results();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d input beats (%0d directed) and %0d result beats", items_sent,
                 DIR_ROWS, results_seen);
        $display("three idle/stall mixes, table filled to capacity %0d times, %0d mismatches",
                 fills_done, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("protected_id_table_unit test passed");
        else
            $display("protected_id_table_unit test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pidt_pkg.sv
rtl/pidt_ctrl.sv
rtl/pidt_dp.sv
rtl/protected_id_table_unit.sv
tb/tb_protected_id_table_unit.sv
